// ===== design/crcfr_pkg.sv =====
// shared types and constants for the crc framed command receiver
package crcfr_pkg;

   localparam logic [7:0]  START_BYTE = 8'h7E;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [7:0]  KIND_FIRST = 8'h01;
   localparam logic [7:0]  KIND_LAST  = 8'h05;
   localparam logic [5:0]  WORD_BYTES = 6'd4;

   localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [1:0] STATUS_BAD_CRC  = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN  = 2'd2;

   typedef enum logic [5:0] {
      PH_START   = 6'b000001,
      PH_KIND    = 6'b000010,
      PH_LENGTH  = 6'b000100,
      PH_PAYLOAD = 6'b001000,
      PH_CRC_LO  = 6'b010000,
      PH_CRC_HI  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0]  frame_kind;
      logic [5:0]  payload_count;
      logic [31:0] payload_word;
      logic        reply_ack;
      logic [1:0]  frame_status;
   } result_type;

endpackage

// ===== design/crc_framed_command_receiver.sv =====
// top level of the crc framed command receiver
//
//   channel  dir  handshake            beat contents
//   req      in   req_valid/req_stall  req_rx_data
//   rsp      out  rsp_valid/rsp_stall  kind, count, word, ack, status
//
// one byte is taken per cycle while req_stall is low; the frame state and crc step together
// a response appears in the cycle after the second crc byte is taken
// a new byte is taken while a response waits; only the closing crc byte
// stalls, and only while the response register is full and stalled
// synchronous reset returns the parser to hunting for the start byte
module crc_framed_command_receiver #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_kind,
   output logic [5:0]  rsp_payload_count,
   output logic [31:0] rsp_payload_word,
   output logic        rsp_reply_ack,
   output logic [1:0]  rsp_frame_status
);
   import crcfr_pkg::*;

   logic       beat;
   logic       res_valid;
   logic       last_phase;
   result_type res;
   result_type out_res;

   assign req_stall = last_phase && rsp_valid && rsp_stall;
   assign beat      = req_valid && !req_stall;

   crcfr_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat),
      .rx_data    (req_rx_data),
      .res_valid  (res_valid),
      .res        (res),
      .last_phase (last_phase)
   );

   crcfr_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .res       (res),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_res   (out_res)
   );

   assign rsp_frame_kind    = out_res.frame_kind;
   assign rsp_payload_count = out_res.payload_count;
   assign rsp_payload_word  = out_res.payload_word;
   assign rsp_reply_ack     = out_res.reply_ack;
   assign rsp_frame_status  = out_res.frame_status;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(res_valid && rsp_valid && rsp_stall))
      else $error("result loaded over a stalled response");

   a_ack_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reply_ack == (rsp_frame_status == STATUS_ACCEPTED)))
      else $error("ack bit disagrees with status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_status == STATUS_ACCEPTED ||
                     rsp_frame_status == STATUS_BAD_CRC ||
                     rsp_frame_status == STATUS_UNKNOWN))
      else $error("status code out of range");

   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload_count != WORD_BYTES) |-> (rsp_payload_word == 32'd0))
      else $error("payload word set for a length other than four");

   a_result_leaves_frame: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> !last_phase)
      else $error("parser did not leave the crc phase after a result");

endmodule

// ===== design/crcfr_crc_byte.sv =====
// crc-16/ccitt-false update over one byte, msb first
module crcfr_crc_byte (
   input  logic [15:0] crc_in,
   input  logic [7:0]  data_in,
   output logic [15:0] crc_out
);
   import crcfr_pkg::*;

   always_comb begin
      logic [15:0] c;
      c = crc_in ^ {data_in, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      crc_out = c;
   end

endmodule

// ===== design/crcfr_parser.sv =====
// frame state machine with running crc and result build
module crcfr_parser #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 beat,
   input  logic [7:0]           rx_data,
   output logic                 res_valid,
   output crcfr_pkg::result_type res,
   output logic                 last_phase
);
   import crcfr_pkg::*;

   localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

   phase_type   phase_ff, phase_in;
   logic [7:0]  kind_ff, kind_in;
   logic [5:0]  length_ff, length_in;
   logic [5:0]  taken_ff, taken_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [31:0] word_ff, word_in;
   logic [15:0] crc_fed;
   logic [5:0]  taken_next;
   logic [15:0] got_crc;
   logic [1:0]  status;

   crcfr_crc_byte u_crc (
      .crc_in  (crc_ff),
      .data_in (rx_data),
      .crc_out (crc_fed)
   );

   assign taken_next = taken_ff + 6'd1;
   assign got_crc    = {rx_data, crc_low_ff};
   assign last_phase = (phase_ff == PH_CRC_HI);

   always_comb begin
      if (got_crc != crc_ff) begin
         status = STATUS_BAD_CRC;
      end else if (kind_ff >= KIND_FIRST && kind_ff <= KIND_LAST) begin
         status = STATUS_ACCEPTED;
      end else begin
         status = STATUS_UNKNOWN;
      end
      res.frame_kind    = kind_ff;
      res.payload_count = length_ff;
      res.payload_word  = (length_ff == WORD_BYTES) ? word_ff : 32'd0;
      res.reply_ack     = (status == STATUS_ACCEPTED);
      res.frame_status  = status;
   end

   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      length_in  = length_ff;
      taken_in   = taken_ff;
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;
      word_in    = word_ff;
      res_valid  = 1'b0;
      if (beat) begin
         case (phase_ff)
            PH_START: begin
               if (rx_data == START_BYTE) begin
                  crc_in   = CRC_INIT;
                  phase_in = PH_KIND;
               end
            end
            PH_KIND: begin
               kind_in  = rx_data;
               crc_in   = crc_fed;
               phase_in = PH_LENGTH;
            end
            PH_LENGTH: begin
               taken_in = 6'd0;
               word_in  = 32'd0;
               if (rx_data > MaxLen) begin
                  phase_in = PH_START;
               end else begin
                  length_in = rx_data[5:0];
                  crc_in    = crc_fed;
                  phase_in  = (rx_data != 8'd0) ? PH_PAYLOAD : PH_CRC_LO;
               end
            end
            PH_PAYLOAD: begin
               if (taken_ff < WORD_BYTES) begin
                  word_in = word_ff | ({24'd0, rx_data} << {taken_ff[1:0], 3'b000});
               end
               crc_in   = crc_fed;
               taken_in = taken_next;
               if (taken_next >= length_ff) begin
                  phase_in = PH_CRC_LO;
               end
            end
            PH_CRC_LO: begin
               crc_low_in = rx_data;
               phase_in   = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               res_valid = 1'b1;
               phase_in  = PH_START;
            end
            default: begin
               phase_in = PH_START;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         kind_ff    <= 8'd0;
         length_ff  <= 6'd0;
         taken_ff   <= 6'd0;
         crc_ff     <= CRC_INIT;
         crc_low_ff <= 8'd0;
         word_ff    <= 32'd0;
      end else begin
         phase_ff   <= phase_in;
         kind_ff    <= kind_in;
         length_ff  <= length_in;
         taken_ff   <= taken_in;
         crc_ff     <= crc_in;
         crc_low_ff <= crc_low_in;
         word_ff    <= word_in;
      end
   end

endmodule

// ===== design/crcfr_out_reg.sv =====
// result register toward the response channel
module crcfr_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  crcfr_pkg::result_type res,
   input  logic                 out_stall,
   output logic                 out_valid,
   output crcfr_pkg::result_type out_res
);
   import crcfr_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (valid_ff && !out_stall) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;

endmodule

// ===== tb/tb.sv =====
// testbench for the crc framed command receiver: directed and random framed byte stream checked by a parser model
`timescale 1ns / 100ps

module tb;
   import crcfr_pkg::*;

   localparam int PAYLOAD_LIMIT = 32;
   localparam int HALF_PERIOD   = 6;
   localparam int RANDOM_BYTES  = 1500;
   localparam int HOLD_AT       = 300;
   localparam int HOLD_CYCLES   = 150;
   localparam int CALM_FROM     = 800;
   localparam int CALM_TO       = 1200;
   localparam int DRAIN_CYCLES  = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_data = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_frame_kind;
   logic [5:0]  rsp_payload_count;
   logic [31:0] rsp_payload_word;
   logic        rsp_reply_ack;
   logic [1:0]  rsp_frame_status;

   crc_framed_command_receiver #(
      .MAX_PAYLOAD(PAYLOAD_LIMIT)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_data       (req_rx_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_kind    (rsp_frame_kind),
      .rsp_payload_count (rsp_payload_count),
      .rsp_payload_word  (rsp_payload_word),
      .rsp_reply_ack     (rsp_reply_ack),
      .rsp_frame_status  (rsp_frame_status)
   );

   always #HALF_PERIOD clock = ~clock;

   logic [7:0]  pending_bytes[$];
   result_type  owed_replies[$];
   int          cycle_no = 0;
   int          hold_left = 0;
   int          mismatch_count = 0;
   int          beats_in = 0;
   int          replies_seen = 0;
   int          acks_seen = 0;
   int          bad_crc_seen = 0;
   int          unknown_seen = 0;

   phase_type   parse_phase = PH_START;
   logic [7:0]  held_kind;
   logic [5:0]  held_len;
   logic [5:0]  taken;
   logic [15:0] run_crc;
   logic [7:0]  crc_lo;
   logic [31:0] word_acc;

   wire calm = (cycle_no >= CALM_FROM) && (cycle_no < CALM_TO);

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++)
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, output result_type reply);
      logic [15:0] got;
      logic [1:0]  status;
      reply = '0;
      case (parse_phase)
         PH_START: begin
            if (b == START_BYTE) begin
               run_crc = CRC_INIT;
               parse_phase = PH_KIND;
            end
         end
         PH_KIND: begin
            held_kind = b;
            run_crc = crc16_byte(run_crc, b);
            parse_phase = PH_LENGTH;
         end
         PH_LENGTH: begin
            taken = '0;
            word_acc = '0;
            if (b > PAYLOAD_LIMIT) begin
               parse_phase = PH_START;
            end else begin
               held_len = b[5:0];
               run_crc = crc16_byte(run_crc, b);
               parse_phase = (b != 8'h00) ? PH_PAYLOAD : PH_CRC_LO;
            end
         end
         PH_PAYLOAD: begin
            if (taken < WORD_BYTES)
               word_acc = word_acc | (32'(b) << (8 * taken));
            run_crc = crc16_byte(run_crc, b);
            taken = taken + 6'd1;
            if (taken >= held_len)
               parse_phase = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            crc_lo = b;
            parse_phase = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            got = {b, crc_lo};
            if (got != run_crc)
               status = STATUS_BAD_CRC;
            else if (held_kind >= KIND_FIRST && held_kind <= KIND_LAST)
               status = STATUS_ACCEPTED;
            else
               status = STATUS_UNKNOWN;
            reply.frame_kind    = held_kind;
            reply.payload_count = held_len;
            reply.payload_word  = (held_len == WORD_BYTES) ? word_acc : 32'h0;
            reply.reply_ack     = (status == STATUS_ACCEPTED);
            reply.frame_status  = status;
            parse_phase = PH_START;
            return 1'b1;
         end
         default: parse_phase = PH_START;
      endcase
      return 1'b0;
   endfunction

   task automatic queue_frame(input logic [7:0] kind, input logic [7:0] body[$],
                              input logic [15:0] crc_flip);
      logic [15:0] crc;
      crc = crc16_byte(CRC_INIT, kind);
      crc = crc16_byte(crc, 8'(body.size()));
      pending_bytes.push_back(START_BYTE);
      pending_bytes.push_back(kind);
      pending_bytes.push_back(8'(body.size()));
      foreach (body[i]) begin
         crc = crc16_byte(crc, body[i]);
         pending_bytes.push_back(body[i]);
      end
      crc = crc ^ crc_flip;
      pending_bytes.push_back(crc[7:0]);
      pending_bytes.push_back(crc[15:8]);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch in %s: expected %h, got %h (cycle %0d)", what, want, got, cycle_no);
   endtask

   always @(posedge clock) cycle_no <= cycle_no + 1;

   // byte driver and frame predictor
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         parse_phase = PH_START;
         held_kind = '0;
         held_len = '0;
         taken = '0;
         run_crc = CRC_INIT;
         crc_lo = '0;
         word_acc = '0;
      end else begin
         if (req_valid && !req_stall) begin : take_beat
            result_type reply;
            beats_in++;
            if (parse_byte(req_rx_data, reply))
               owed_replies.push_back(reply);
         end
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
               req_valid   <= 1'b1;
               req_rx_data <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall, with one long hold-off to back up the input
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (cycle_no == HOLD_AT)
            hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 7);
         end
      end
   end

   // response checker
   always @(posedge clock) begin : watch_replies
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         replies_seen++;
         case (rsp_frame_status)
            STATUS_ACCEPTED: acks_seen++;
            STATUS_BAD_CRC:  bad_crc_seen++;
            STATUS_UNKNOWN:  unknown_seen++;
            default: ;
         endcase
         if (owed_replies.size() == 0) begin
            report_mismatch("unexpected response beat, kind", 32'h0, 32'(rsp_frame_kind));
         end else begin
            want = owed_replies.pop_front();
            if (rsp_frame_kind !== want.frame_kind)
               report_mismatch("frame_kind", 32'(want.frame_kind), 32'(rsp_frame_kind));
            if (rsp_payload_count !== want.payload_count)
               report_mismatch("payload_count", 32'(want.payload_count),
                               32'(rsp_payload_count));
            if (rsp_payload_word !== want.payload_word)
               report_mismatch("payload_word", want.payload_word, rsp_payload_word);
            if (rsp_reply_ack !== want.reply_ack)
               report_mismatch("reply_ack", 32'(want.reply_ack), 32'(rsp_reply_ack));
            if (rsp_frame_status !== want.frame_status)
               report_mismatch("frame_status", 32'(want.frame_status),
                               32'(rsp_frame_status));
         end
      end
   end

   initial begin
      logic [7:0]  body[$];
      logic [7:0]  kind;
      logic [7:0]  b;
      logic [15:0] flip;
      int          pick;
      int          len;
      int          target;

      // directed part
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      body = {};
      queue_frame(KIND_FIRST, body, 16'h0000);
      body = '{8'h7E, 8'h00, 8'hFF, 8'h80};
      queue_frame(8'hFF, body, 16'h0000);
      body = {};
      queue_frame(KIND_LAST, body, 16'h8001);
      pending_bytes.push_back(START_BYTE);
      pending_bytes.push_back(8'h02);
      pending_bytes.push_back(8'hFF);

      // random part
      target = pending_bytes.size() + RANDOM_BYTES;
      while (pending_bytes.size() < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            kind = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(KIND_FIRST, KIND_LAST))
                                               : 8'($urandom_range(0, 255));
            len = $urandom_range(0, 9);
            if (len < 5)
               len = WORD_BYTES;
            else if (len < 9)
               len = $urandom_range(0, 8);
            else
               len = $urandom_range(0, PAYLOAD_LIMIT);
            body = {};
            repeat (len) body.push_back(8'($urandom_range(0, 255)));
            flip = (pick < 70) ? 16'h0000 : 16'($urandom_range(1, 16'hFFFF));
            queue_frame(kind, body, flip);
         end else if (pick < 88) begin
            pending_bytes.push_back(START_BYTE);
            pending_bytes.push_back(8'($urandom_range(0, 255)));
            pending_bytes.push_back(8'($urandom_range(PAYLOAD_LIMIT + 1, 255)));
         end else if (pick < 94) begin
            repeat ($urandom_range(1, 4)) begin
               b = 8'($urandom_range(0, 255));
               pending_bytes.push_back((b == START_BYTE) ? 8'h00 : b);
            end
         end else begin
            len = $urandom_range(1, PAYLOAD_LIMIT);
            pending_bytes.push_back(START_BYTE);
            pending_bytes.push_back(8'($urandom_range(0, 255)));
            pending_bytes.push_back(8'(len));
            repeat ($urandom_range(0, len - 1))
               pending_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_valid) @(negedge clock);
      while (owed_replies.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      #1;
      if (owed_replies.size() != 0) begin
         mismatch_count += owed_replies.size();
         $display("%0d expected responses never arrived", owed_replies.size());
      end

      $display("run covered %0d input bytes and %0d frame responses", beats_in, replies_seen);
      $display("responses: %0d accepted, %0d crc errors, %0d unknown commands",
               acks_seen, bad_crc_seen, unknown_seen);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #1200000;
      $display("timeout after %0d cycles", cycle_no);
      $display("Mismatches found");
      $finish;
   end

endmodule
